[rtl/tbpc_pkg.sv]
package tbpc_pkg;

    localparam int MAX_TILES          = 1024;
    localparam int PALETTES_PER_LAYER = 16;
    localparam int VIEW_WIDTH         = 320;
    localparam int VIEW_HEIGHT        = 240;
    localparam int MAP_CELLS_SIDE     = 32;

    localparam int LAYERS       = 3;
    localparam int MAP_DEPTH    = MAP_CELLS_SIDE * MAP_CELLS_SIDE;
    localparam int MAP_AW       = $clog2(MAP_DEPTH);
    localparam int TILE_DEPTH   = MAX_TILES * 32;
    localparam int TILE_AW      = $clog2(TILE_DEPTH);
    localparam int TILE_NUM_W   = $clog2(MAX_TILES);
    localparam int PAL_DEPTH    = PALETTES_PER_LAYER * 16;
    localparam int PAL_AW       = $clog2(PAL_DEPTH);
    localparam int PAL_NUM_W    = (PALETTES_PER_LAYER > 1) ? $clog2(PALETTES_PER_LAYER) : 1;
    localparam int ROW_AW       = $clog2(VIEW_HEIGHT);

    localparam logic [15:0] ALPHA_BIT  = 16'h8000;
    localparam logic [14:0] COLOR_MASK = 15'h7FFF;
    localparam logic [3:0]  PIX_MASK   = 4'h0F;
    localparam logic [4:0]  NIB_TOP    = 5'd28;
    localparam int          DIS_BIT    = 15;

    typedef enum logic [2:0] {
        OP_MAP    = 3'd0,
        OP_TILE   = 3'd1,
        OP_PAL    = 3'd2,
        OP_ROW_X  = 3'd3,
        OP_ROW_Y  = 3'd4,
        OP_RENDER = 3'd5
    } t_op_e;

    typedef enum logic {
        REG_ORIGIN_X = 1'b0,
        REG_ORIGIN_Y = 1'b1
    } t_reg_e;

    // 50/50 average per RGB555 channel
    function automatic logic [14:0] blend_half(input logic [14:0] a, input logic [14:0] b);
        logic [5:0] r, g, bl;
        r  = {1'b0, a[14:10]} + {1'b0, b[14:10]};
        g  = {1'b0, a[9:5]}   + {1'b0, b[9:5]};
        bl = {1'b0, a[4:0]}   + {1'b0, b[4:0]};
        return {r[5:1], g[5:1], bl[5:1]};
    endfunction

endpackage

[rtl/tbpc_in_if.sv]
interface tbpc_in_if;
    import tbpc_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [1:0]  layer_sel;
    logic [14:0] store_index;
    logic [31:0] store_value;
    logic [8:0]  pixel_x;
    logic [7:0]  pixel_y;
    modport source (output valid, op, layer_sel, store_index, store_value, pixel_x, pixel_y,
                    input ready);
    modport sink (input valid, op, layer_sel, store_index, store_value, pixel_x, pixel_y,
                  output ready);
endinterface

[rtl/tbpc_out_if.sv]
interface tbpc_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] pixel_color;
    modport source (output valid, pixel_color, input ready);
    modport sink (input valid, pixel_color, output ready);
endinterface

[rtl/tile_background_pixel_composer.sv]
// Three-layer tile-map background composer. Each word on the input channel either loads
// one store entry (map cell, tile pixel word, palette color, row x or y shift) or asks for
// the pixel at (pixel_x, pixel_y); only render words give a word on the output channel.
// One word is taken per clock while i_pix_in.ready is high; it is low during the row
// clear and while the output word is held. A pixel word is offered from the fifth
// register of a pipeline of one memory read per stage: row shifts, map cell, tile word,
// palette color, then the blend into the output register. Writes travel down the same
// pipeline and land at the stage that reads their store, so every word sees exactly the
// writes that came before it. After reset the row shift stores are cleared over all
// VIEW_HEIGHT rows (240) with i_pix_in.ready low; configuration writes still land. The user
// must write origin registers only while no render word is in flight; the block does not enforce it.
module tile_background_pixel_composer
    import tbpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [8:0]  i_cfg_data,
    tbpc_in_if.sink     i_pix_in,
    tbpc_out_if.source  o_pix_out
);

    // memories, one set per layer
    logic [8:0]  r_rowx_mem [LAYERS][VIEW_HEIGHT];
    logic [8:0]  r_rowy_mem [LAYERS][VIEW_HEIGHT];
    logic [15:0] r_map_mem  [LAYERS][MAP_DEPTH];
    logic [31:0] r_tile_mem [LAYERS][TILE_DEPTH];
    logic [15:0] r_pal_mem  [LAYERS][PAL_DEPTH];

    logic [8:0] r_org_x, r_org_y;
    logic       r_clr;
    logic [ROW_AW-1:0] r_clr_cnt;

    logic en, acc;

    // stage 1: row shift read
    logic        r1_v, r1_rowok;
    logic [2:0]  r1_op;
    logic [1:0]  r1_lay;
    logic [14:0] r1_idx;
    logic [31:0] r1_val;
    logic [8:0]  r1_px;
    logic [7:0]  r1_py;
    logic [8:0]  r1_sx [LAYERS];
    logic [8:0]  r1_sy [LAYERS];
    // stage 2: map read
    logic        r2_v;
    logic [2:0]  r2_op;
    logic [1:0]  r2_lay;
    logic [14:0] r2_idx;
    logic [31:0] r2_val;
    logic [3:0]  r2_inx [LAYERS];
    logic [3:0]  r2_iny [LAYERS];
    logic [15:0] r2_ent [LAYERS];
    // stage 3: tile read
    logic        r3_v;
    logic [2:0]  r3_op;
    logic [1:0]  r3_lay;
    logic [14:0] r3_idx;
    logic [31:0] r3_val;
    logic [2:0]  r3_inx [LAYERS];
    logic [15:0] r3_ent [LAYERS];
    logic [31:0] r3_word [LAYERS];
    // stage 4: palette read
    logic        r4_v;
    logic [LAYERS-1:0] r4_dis, r4_pz;
    logic [15:0] r4_col [LAYERS];
    // output register
    logic        r_ov;
    logic [14:0] r_ocol;

    // pipeline moves unless the output word is held
    assign en  = !r_ov || o_pix_out.ready;
    assign i_pix_in.ready = en && !r_clr;
    assign acc = i_pix_in.valid && i_pix_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x   <= '0;
            r_org_y   <= '0;
            r_clr     <= 1'b1;
            r_clr_cnt <= '0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ORIGIN_X: r_org_x <= i_cfg_data;
                    REG_ORIGIN_Y: r_org_y <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == ROW_AW'(VIEW_HEIGHT - 1))
                    r_clr <= 1'b0;
            end
            if (en) begin
                r1_v <= acc;
                r2_v <= r1_v;
                r3_v <= r2_v;
                r4_v <= r3_v && (r3_op == OP_RENDER);
                r_ov <= r4_v;
            end
        end
    end

    // payload of the stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_op  <= i_pix_in.op;
            r1_lay <= i_pix_in.layer_sel;
            r1_idx <= i_pix_in.store_index;
            r1_val <= i_pix_in.store_value;
            r1_px  <= i_pix_in.pixel_x;
            r1_py  <= i_pix_in.pixel_y;
            r1_rowok <= ({1'b0, i_pix_in.pixel_y} < 9'(VIEW_HEIGHT));
            r2_op <= r1_op;  r2_lay <= r1_lay;  r2_idx <= r1_idx;  r2_val <= r1_val;
            r3_op <= r2_op;  r3_lay <= r2_lay;  r3_idx <= r2_idx;  r3_val <= r2_val;
        end
    end

    // stage 0/1: row shift stores, cleared after reset
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LAYERS; l++) begin
            if (r_clr) begin
                r_rowx_mem[l][r_clr_cnt] <= '0;
                r_rowy_mem[l][r_clr_cnt] <= '0;
            end else if (acc && i_pix_in.layer_sel == 2'(l)
                         && i_pix_in.store_index < 15'(VIEW_HEIGHT)) begin
                if (i_pix_in.op == OP_ROW_X)
                    r_rowx_mem[l][i_pix_in.store_index[ROW_AW-1:0]] <= i_pix_in.store_value[8:0];
                if (i_pix_in.op == OP_ROW_Y)
                    r_rowy_mem[l][i_pix_in.store_index[ROW_AW-1:0]] <= i_pix_in.store_value[8:0];
            end
            if (en) begin
                r1_sx[l] <= r_rowx_mem[l][i_pix_in.pixel_y[ROW_AW-1:0]];
                r1_sy[l] <= r_rowy_mem[l][i_pix_in.pixel_y[ROW_AW-1:0]];
            end
        end
    end

    // stage 1 -> 2: source coordinates, map cell read
    logic [8:0] s1_xs [LAYERS];
    logic [8:0] s1_ys [LAYERS];
    always_comb begin
        for (int l = 0; l < LAYERS; l++) begin
            s1_xs[l] = r1_px + r_org_x - (r1_rowok ? r1_sx[l] : 9'd0);
            s1_ys[l] = {1'b0, r1_py} + r_org_y - (r1_rowok ? r1_sy[l] : 9'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LAYERS; l++) begin
            if (en && r1_v && r1_op == OP_MAP && r1_lay == 2'(l)
                && {1'b0, r1_idx} < 16'(MAP_DEPTH))
                r_map_mem[l][r1_idx[MAP_AW-1:0]] <= r1_val[15:0];
            if (en) begin
                r2_ent[l] <= r_map_mem[l][{s1_ys[l][8:4], s1_xs[l][8:4]}];
                r2_inx[l] <= s1_xs[l][3:0];
                r2_iny[l] <= s1_ys[l][3:0];
            end
        end
    end

    // stage 2 -> 3: tile word read
    logic [TILE_AW-1:0] s2_taddr [LAYERS];
    always_comb begin
        for (int l = 0; l < LAYERS; l++)
            s2_taddr[l] = {r2_ent[l][TILE_NUM_W-1:0], r2_iny[l], r2_inx[l][3]};
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LAYERS; l++) begin
            if (en && r2_v && r2_op == OP_TILE && r2_lay == 2'(l)
                && {1'b0, r2_idx} < 16'(TILE_DEPTH))
                r_tile_mem[l][r2_idx[TILE_AW-1:0]] <= r2_val;
            if (en) begin
                r3_word[l] <= r_tile_mem[l][s2_taddr[l]];
                r3_ent[l]  <= r2_ent[l];
                r3_inx[l]  <= r2_inx[l][2:0];
            end
        end
    end

    // stage 3 -> 4: pick nibble, palette read
    logic [31:0]       s3_sh   [LAYERS];
    logic [3:0]        s3_pix  [LAYERS];
    logic [PAL_AW-1:0] s3_paddr [LAYERS];
    always_comb begin
        for (int l = 0; l < LAYERS; l++) begin
            s3_sh[l]  = r3_word[l] >> (NIB_TOP - {r3_inx[l], 2'b00});
            s3_pix[l] = s3_sh[l][3:0] & PIX_MASK;
            // disabled cell reads color 0 of its palette
            s3_paddr[l] = {r3_ent[l][10 +: PAL_NUM_W],
                           r3_ent[l][DIS_BIT] ? 4'd0 : s3_pix[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LAYERS; l++) begin
            if (en && r3_v && r3_op == OP_PAL && r3_lay == 2'(l)
                && {1'b0, r3_idx} < 16'(PAL_DEPTH))
                r_pal_mem[l][r3_idx[PAL_AW-1:0]] <= r3_val[15:0];
            if (en) begin
                r4_col[l] <= r_pal_mem[l][s3_paddr[l]];
                r4_dis[l] <= r3_ent[l][DIS_BIT];
                r4_pz[l]  <= (s3_pix[l] == 4'd0);
            end
        end
    end

    // stage 4 -> out: back layer, then middle and front overlays
    logic [14:0] s4_acc2, s4_acc1, s4_acc0;
    always_comb begin
        s4_acc2 = r4_col[2][14:0] & COLOR_MASK;
        s4_acc1 = s4_acc2;
        if (!r4_dis[1] && !r4_pz[1])
            s4_acc1 = (r4_col[1] & ALPHA_BIT) != 16'd0 ? blend_half(r4_col[1][14:0], s4_acc2)
                                                        : r4_col[1][14:0];
        s4_acc0 = s4_acc1;
        if (!r4_dis[0] && !r4_pz[0])
            s4_acc0 = (r4_col[0] & ALPHA_BIT) != 16'd0 ? blend_half(r4_col[0][14:0], s4_acc1)
                                                        : r4_col[0][14:0];
    end

    always_ff @(posedge i_clk) begin
        if (en)
            r_ocol <= s4_acc0;
    end

    assign o_pix_out.valid       = r_ov;
    assign o_pix_out.pixel_color = r_ocol;

endmodule

[rtl/tbpc_checker.sv]
module tbpc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [14:0] out_color
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_color))
        else $error("output word changed while stalled");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !in_ready)
        else $error("input taken during row clear");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output blocked");

endmodule

bind tile_background_pixel_composer tbpc_checker u_tbpc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_ready  (i_pix_in.ready),
    .out_valid (o_pix_out.valid),
    .out_ready (o_pix_out.ready),
    .out_color (o_pix_out.pixel_color)
);

[verif/tbpc_pixel_monitor.sv]
`timescale 1ns / 100ps

module tbpc_pixel_monitor
    import tbpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [8:0] i_cfg_data,
    tbpc_in_if         pix_in,
    tbpc_out_if        pix_out,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int LAYER_FRONT = 0;
    localparam int LAYER_MID   = 1;
    localparam int LAYER_BACK  = 2;

    // shadow copies of the block's stores
    logic [15:0] cell_mem  [LAYERS][MAP_DEPTH];
    logic [31:0] tile_mem  [LAYERS][TILE_DEPTH];
    logic [15:0] color_mem [LAYERS][PAL_DEPTH];
    logic [8:0]  shift_x   [LAYERS][VIEW_HEIGHT];
    logic [8:0]  shift_y   [LAYERS][VIEW_HEIGHT];
    logic [8:0]  origin_x;
    logic [8:0]  origin_y;
    logic [14:0] pixel_q [$];

    function automatic logic [14:0] avg555(input logic [14:0] a, input logic [14:0] b);
        logic [5:0] r, g, bl;
        r  = {1'b0, a[14:10]} + {1'b0, b[14:10]};
        g  = {1'b0, a[9:5]} + {1'b0, b[9:5]};
        bl = {1'b0, a[4:0]} + {1'b0, b[4:0]};
        return {r[5:1], g[5:1], bl[5:1]};
    endfunction

    // one layer painted over acc
    function automatic logic [14:0] paint_layer(input int lay, input logic [8:0] x,
                                                input logic [7:0] y, input bit overlay,
                                                input logic [14:0] acc);
        logic [8:0]  sx, sy, xs, ys;
        logic [15:0] ent, c;
        logic [31:0] word;
        logic [3:0]  pal, pix;
        sx = '0;
        sy = '0;
        if (y < VIEW_HEIGHT) begin
            sx = shift_x[lay][y];
            sy = shift_y[lay][y];
        end
        ys = 9'(y + origin_y - sy);
        xs = 9'(x + origin_x - sx);
        ent = cell_mem[lay][{ys[8:4], xs[8:4]}];
        pal = ent[13:10];
        if (ent[15]) begin
            c = color_mem[lay][{pal, 4'd0}];
            return overlay ? acc : c[14:0];
        end
        word = tile_mem[lay][{ent[9:0], ys[3:0], xs[3]}];
        pix = word[31 - 4 * xs[2:0] -: 4];
        c = color_mem[lay][{pal, pix}];
        if (!overlay) return c[14:0];
        if (pix == 4'd0) return acc;
        if (!c[15]) return c[14:0];
        return avg555(c[14:0], acc);
    endfunction

    function automatic logic [14:0] compose_pixel(input logic [8:0] x, input logic [7:0] y);
        logic [14:0] acc;
        acc = paint_layer(LAYER_BACK, x, y, 1'b0, 15'd0);
        acc = paint_layer(LAYER_MID, x, y, 1'b1, acc);
        return paint_layer(LAYER_FRONT, x, y, 1'b1, acc);
    endfunction

    always @(posedge i_clk) begin
        logic [14:0] want;
        if (!i_rst_n) begin
            origin_x = '0;
            origin_y = '0;
            for (int l = 0; l < LAYERS; l++)
                for (int r = 0; r < VIEW_HEIGHT; r++) begin
                    shift_x[l][r] = '0;
                    shift_y[l][r] = '0;
                end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ORIGIN_X) origin_x = i_cfg_data;
                else origin_y = i_cfg_data;
            end
            if (pix_out.valid && pix_out.ready) begin
                if (pixel_q.size() == 0) begin
                    $error("pixel_color: unexpected word 0x%h", pix_out.pixel_color);
                    o_fail_count++;
                end else begin
                    want = pixel_q.pop_front();
                    if (pix_out.pixel_color !== want) begin
                        $error("pixel_color: expected 0x%h actual 0x%h", want,
                               pix_out.pixel_color);
                        o_fail_count++;
                    end
                end
            end
            if (pix_in.valid && pix_in.ready) begin
                if (pix_in.op == OP_RENDER)
                    pixel_q.push_back(compose_pixel(pix_in.pixel_x, pix_in.pixel_y));
                else if (pix_in.layer_sel < LAYERS) begin
                    case (pix_in.op)
                        OP_MAP:
                            if (pix_in.store_index < MAP_DEPTH)
                                cell_mem[pix_in.layer_sel][pix_in.store_index] =
                                    pix_in.store_value[15:0];
                        OP_TILE:
                            tile_mem[pix_in.layer_sel][pix_in.store_index] =
                                pix_in.store_value;
                        OP_PAL:
                            if (pix_in.store_index < PAL_DEPTH)
                                color_mem[pix_in.layer_sel][pix_in.store_index] =
                                    pix_in.store_value[15:0];
                        OP_ROW_X:
                            if (pix_in.store_index < VIEW_HEIGHT)
                                shift_x[pix_in.layer_sel][pix_in.store_index] =
                                    pix_in.store_value[8:0];
                        OP_ROW_Y:
                            if (pix_in.store_index < VIEW_HEIGHT)
                                shift_y[pix_in.layer_sel][pix_in.store_index] =
                                    pix_in.store_value[8:0];
                        default: ;
                    endcase
                end
            end
        end
        o_pending = pixel_q.size();
    end

endmodule

[verif/tile_background_pixel_composer_test.sv]
`timescale 1ns / 100ps

module tile_background_pixel_composer_test;
    import tbpc_pkg::*;

    // op codes the block must ignore, and the layer select that writes nothing
    localparam logic [2:0] OP_SPARE_A  = 3'd6;
    localparam logic [2:0] OP_SPARE_B  = 3'd7;
    localparam logic [1:0] LAYER_FRONT = 2'd0;
    localparam logic [1:0] LAYER_MID   = 2'd1;
    localparam logic [1:0] LAYER_BACK  = 2'd2;
    localparam logic [1:0] LAYER_NONE  = 2'd3;
    localparam logic [3:0] PAL_LO      = 4'h0;
    localparam logic [3:0] PAL_HI      = 4'hF;
    localparam int         DRAIN_CYC   = 12;    // pipeline is five deep

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_idx = 1'b0;
    logic [8:0] i_cfg_data = '0;
    int         fail_count;
    int         pending;

    bit tx_idle = 1'b0;     // sender gaps on/off
    bit rx_idle = 1'b0;     // receiver stalls on/off
    bit rx_hold = 1'b0;     // one long receiver hold-off

    tbpc_in_if  pix_in();
    tbpc_out_if pix_out();

    tile_background_pixel_composer DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_pix_in  (pix_in),
        .o_pix_out (pix_out)
    );

    tbpc_pixel_monitor pixel_mon (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .pix_in      (pix_in),
        .pix_out     (pix_out),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #4ms;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: per word a random stall, or the long hold-off when asked.
    initial begin : rx_side
        int w;
        pix_out.ready = 1'b0;
        forever begin
            w = (rx_idle && $urandom_range(0, 3) != 0) ? $urandom_range(0, 19) : 0;
            if (rx_hold) begin
                w = 300;
                rx_hold = 1'b0;
            end
            if (w > 0) begin
                @(negedge i_clk) pix_out.ready <= 1'b0;
                repeat (w - 1) @(negedge i_clk);
            end
            @(negedge i_clk) pix_out.ready <= 1'b1;
            do @(posedge i_clk); while (!pix_out.valid);
        end
    end

    // Sender: called right after an accept edge, so valid changes once per step.
    task automatic send_word(input logic [2:0] op, input logic [1:0] lay,
                             input logic [14:0] idx, input logic [31:0] val,
                             input logic [8:0] x, input logic [7:0] y);
        int gap;
        gap = (tx_idle && $urandom_range(0, 2) != 0) ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            @(negedge i_clk) pix_in.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pix_in.valid       <= 1'b1;
        pix_in.op          <= op;
        pix_in.layer_sel   <= lay;
        pix_in.store_index <= idx;
        pix_in.store_value <= val;
        pix_in.pixel_x     <= x;
        pix_in.pixel_y     <= y;
        do @(posedge i_clk); while (!pix_in.ready);
    endtask

    task automatic write_origin(input t_reg_e r, input logic [8:0] v);
        @(negedge i_clk);
        pix_in.valid <= 1'b0;
        i_cfg_we     <= 1'b1;
        i_cfg_idx    <= r;
        i_cfg_data   <= v;
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // sender pauses until every pixel is out and the pipe has drained
    task automatic drain();
        @(negedge i_clk) pix_in.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // Maps only ever point at tiles 0, 1, 1022 and 1023 and at palettes 0 and 15, which
    // are fully loaded. Random renders stay in columns and rows 0..31 with origins and
    // row shifts of 0..15 or -1, so they only reach map rows and columns 31, 0, 1 and 2.
    function automatic logic [9:0] tile_at(input int n);
        return (n < 2) ? 10'(n) : 10'(1020 + n);
    endfunction

    function automatic logic [9:0] pick_tile();
        return tile_at(int'($urandom_range(0, 3)));
    endfunction

    function automatic logic [3:0] pick_pal();
        return ($urandom_range(0, 1) != 0) ? PAL_HI : PAL_LO;
    endfunction

    function automatic logic [8:0] pick_shift();
        return ($urandom_range(0, 7) == 0) ? 9'h1FF : 9'($urandom_range(0, 15));
    endfunction

    function automatic logic [14:0] map_cell(input int r, input int c);
        return 15'(((r + 32) % 32) * 32 + (c + 32) % 32);
    endfunction

    task automatic send_random();
        int          k;
        logic [1:0]  lay;
        logic [2:0]  op;
        logic [14:0] idx;
        logic [31:0] v;
        k   = $urandom_range(0, 99);
        lay = ($urandom_range(0, 15) == 0) ? LAYER_NONE : 2'($urandom_range(0, 2));
        v   = $urandom;
        idx = 15'($urandom);
        op  = OP_RENDER;
        if (k < 45) begin
            lay = 2'($urandom);
        end else if (k < 60) begin
            op = OP_MAP;
            if ($urandom_range(0, 15) != 0)
                idx = map_cell(int'($urandom_range(0, 3)) - 1, int'($urandom_range(0, 3)) - 1);
            v[13:10] = pick_pal();
            v[9:0]   = pick_tile();
        end else if (k < 72) begin
            op = OP_TILE;
            if ($urandom_range(0, 3) != 0) idx = {pick_tile(), 5'($urandom)};
        end else if (k < 84) begin
            op = OP_PAL;
            if ($urandom_range(0, 15) != 0) idx = 15'({pick_pal(), 4'($urandom)});
        end else if (k < 96) begin
            op = (k < 90) ? OP_ROW_X : OP_ROW_Y;
            if ($urandom_range(0, 15) != 0)
                idx = 15'($urandom_range(0, ($urandom_range(0, 3) == 0) ? VIEW_HEIGHT - 1 : 31));
            v[8:0] = pick_shift();
        end else begin
            op = (k < 98) ? OP_SPARE_A : OP_SPARE_B;
        end
        send_word(op, lay, idx, v, 9'($urandom_range(0, 31)), 8'($urandom_range(0, 31)));
    endtask

    initial begin
        logic [1:0] lay;
        logic [9:0] t;
        logic [8:0] ox, oy;
        pix_in.valid       = 1'b0;
        pix_in.op          = OP_MAP;
        pix_in.layer_sel   = LAYER_FRONT;
        pix_in.store_index = '0;
        pix_in.store_value = '0;
        pix_in.pixel_x     = '0;
        pix_in.pixel_y     = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        write_origin(REG_ORIGIN_X, 9'd0);
        write_origin(REG_ORIGIN_Y, 9'd0);

        // load the palettes, tiles and map cells that renders can reach, at full rate
        for (int l = 0; l < 3; l++) begin
            lay = 2'(l);
            for (int i = 0; i < 32; i++)
                send_word(OP_PAL, lay, 15'({(i < 16) ? PAL_LO : PAL_HI, 4'(i)}),
                          $urandom, '0, '0);
            for (int n = 0; n < 4; n++) begin
                t = tile_at(n);
                for (int w = 0; w < 32; w++)
                    send_word(OP_TILE, lay, {t, 5'(w)}, $urandom, '0, '0);
            end
            for (int r = -1; r < 3; r++)
                for (int c = -1; c < 3; c++)
                    send_word(OP_MAP, lay, map_cell(r, c),
                              {16'($urandom), 2'($urandom), pick_pal(), pick_tile()}, '0, '0);
            // cells under the far view corner and under the row beyond the view
            send_word(OP_MAP, lay, map_cell(14, 19),
                      {16'($urandom), 2'($urandom), pick_pal(), pick_tile()}, '0, '0);
            send_word(OP_MAP, lay, map_cell(15, 31),
                      {16'($urandom), 2'($urandom), pick_pal(), pick_tile()}, '0, '0);
        end

        // directed corners and special cases
        send_word(OP_RENDER, LAYER_FRONT, '0, '0, 9'd0, 8'd0);
        send_word(OP_RENDER, LAYER_FRONT, '0, '0, 9'd319, 8'd239);
        send_word(OP_RENDER, LAYER_NONE, '1, '1, 9'd511, 8'd255);   // row beyond view
        // every layer disabled at cell 0: back gives its palette color 0
        send_word(OP_MAP, LAYER_BACK, 15'd0, 32'hFFFF_BC05, '0, '0);
        send_word(OP_MAP, LAYER_MID, 15'd0, 32'h0000_8000, '0, '0);
        send_word(OP_MAP, LAYER_FRONT, 15'd0, 32'h0000_8000, '0, '0);
        send_word(OP_RENDER, LAYER_FRONT, '0, '0, 9'd0, 8'd0);
        // front enabled: transparent nibble, blended color, opaque color
        send_word(OP_MAP, LAYER_FRONT, 15'd0, 32'h0000_3C00, '0, '0);
        send_word(OP_TILE, LAYER_FRONT, 15'd0, 32'h0123_4567, '0, '0);
        send_word(OP_PAL, LAYER_FRONT, 15'd241, 32'h0000_FFFF, '0, '0);
        send_word(OP_PAL, LAYER_FRONT, 15'd242, 32'h0000_7FFF, '0, '0);
        send_word(OP_MAP, LAYER_MID, 15'd0, 32'h0000_03FF, '0, '0);  // top tile number
        for (int x = 0; x < 3; x++)
            send_word(OP_RENDER, LAYER_FRONT, '0, '0, 9'(x), 8'd0);
        // ignored writes: no layer, spare ops, index past the store
        send_word(OP_MAP, LAYER_NONE, 15'd0, 32'h0000_8000, '0, '0);
        send_word(OP_SPARE_A, LAYER_FRONT, 15'd0, '1, '0, '0);
        send_word(OP_SPARE_B, LAYER_BACK, '1, '1, '1, '1);
        send_word(OP_MAP, LAYER_FRONT, 15'd1024, 32'h0000_8000, '0, '0);
        send_word(OP_ROW_X, LAYER_FRONT, 15'd240, '1, '0, '0);
        // row shifts at their extremes
        send_word(OP_ROW_X, LAYER_FRONT, 15'd0, 32'h0000_01FF, '0, '0);
        send_word(OP_ROW_Y, LAYER_MID, 15'd0, 32'hFFFF_FFFF, '0, '0);
        send_word(OP_RENDER, LAYER_FRONT, '0, '0, 9'd0, 8'd0);
        drain();

        // random phases over several origin settings, extremes included
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin ox = 9'd511; oy = 9'd511; end
                1: begin ox = 9'd0;   oy = 9'd511; end
                default: begin
                    ox = 9'($urandom_range(0, 15));
                    oy = 9'($urandom_range(0, 15));
                end
            endcase
            write_origin(REG_ORIGIN_X, ox);
            write_origin(REG_ORIGIN_Y, oy);
            for (int i = 0; i < 240; i++) begin
                if (i % 50 == 0) begin
                    tx_idle = $urandom_range(0, 3) != 0;
                    rx_idle = $urandom_range(0, 3) != 0;
                end
                // long output hold while renders keep coming: input must back up
                if (ph == 1 && i == 100) begin
                    tx_idle = 1'b0;
                    rx_hold = 1'b1;
                    repeat (40) send_word(OP_RENDER, 2'($urandom), 15'($urandom), $urandom,
                                          9'($urandom_range(0, 31)),
                                          8'($urandom_range(0, 31)));
                end
                send_random();
            end
            drain();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/tbpc_pkg.sv
rtl/tbpc_in_if.sv
rtl/tbpc_out_if.sv
rtl/tile_background_pixel_composer.sv
rtl/tbpc_checker.sv
verif/tbpc_pixel_monitor.sv
verif/tile_background_pixel_composer_test.sv
